/* rtl/ppp_pkg.sv */
// Shared types, constants and register codes for the pinhole point projection.
// No dependencies; every other file of the block imports this package.
package ppp_pkg;

  // Default pipeline widths for camera and clip coordinates
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths
  localparam int COEF_W    = 32;
  localparam int POINT_W   = 32;
  localparam int IDX_W     = 5;
  localparam int VP_W      = 13;
  localparam int PIX_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int QUO_W     = 16;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 4'd1;
  localparam logic [VP_W-1:0]      VP_WIDTH_RST  = 13'd640;
  localparam logic [VP_W-1:0]      VP_HEIGHT_RST = 13'd480;

  // Input action code for a coefficient write
  localparam logic ACTION_WRITE = 1'b0;

  // Pixel clamp limits
  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_W_ZERO = 2'd1,
    STATUS_SAT    = 2'd2
  } status_e;

  // Control bits that travel with each item through the transform stages
  typedef struct packed {
    logic valid;
    logic write;
    logic behind;
  } ppp_ctl_t;

  // Side information that travels with each point through the divider
  typedef struct packed {
    logic behind;
    logic w_zero;
    logic neg_x;
    logic neg_y;
  } ppp_tag_t;

endpackage

/* rtl/ppp_camera.sv */
// Extrinsic stage group: holds the extrinsic matrix and forms camera coordinates
// and the behind-camera flag over four register stages. Depends on ppp_pkg.
module ppp_camera #(
  parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ppp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                action_i,
  input  logic [ppp_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [ppp_pkg::COEF_W-1:0]   coef_value_i,
  input  logic signed [ppp_pkg::POINT_W-1:0]  point_x_i,
  input  logic signed [ppp_pkg::POINT_W-1:0]  point_y_i,
  input  logic signed [ppp_pkg::POINT_W-1:0]  point_z_i,
  output ppp_pkg::ppp_ctl_t                   ctl_o,
  output logic [ppp_pkg::IDX_W-1:0]           wr_index_o,
  output logic signed [ppp_pkg::COEF_W-1:0]   wr_value_o,
  output logic signed [COORD_WIDTH-1:0]       cam_o [4]
);
  import ppp_pkg::*;

  localparam int PW = POINT_W + COEF_W;
  localparam int BW = PW + 2;
  localparam int SW = ((COORD_WIDTH > COEF_W) ? COORD_WIDTH : COEF_W) + 2;
  localparam logic signed [PW-1:0] RND    = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic signed [PW-1:0] SAT_HI = (PW'(1) << (COORD_WIDTH - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SAT_LO = -(PW'(1) << (COORD_WIDTH - 1));
  localparam logic signed [SW-1:0] SUM_HI = (SW'(1) << (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SUM_LO = -(SW'(1) << (COORD_WIDTH - 1));

  ppp_ctl_t                     s0_ctl_q, s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [IDX_W-1:0]             s0_idx_q, s1_idx_q, s2_idx_q, s3_idx_q;
  logic signed [COEF_W-1:0]     s0_val_q, s1_val_q, s2_val_q, s3_val_q;
  logic signed [POINT_W-1:0]    s0_p_q [3];
  logic signed [COEF_W-1:0]     ext_q [16];
  logic signed [PW-1:0]         s1_prod_q [4][3];
  logic signed [COEF_W-1:0]     s1_trans_q [4];
  logic signed [COORD_WIDTH-1:0] s2_qm_d [4][3];
  logic signed [COORD_WIDTH-1:0] s2_qm_q [4][3];
  logic signed [COEF_W-1:0]     s2_trans_q [4];
  logic signed [COORD_WIDTH-1:0] s3_cam_d [4];
  logic signed [COORD_WIDTH-1:0] s3_cam_q [4];
  logic signed [BW-1:0]         fwd_sum;

  // Advance control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else if (en_i) begin
      s0_ctl_q <= '{valid: valid_i, write: (action_i == ACTION_WRITE), behind: 1'b0};
      s1_ctl_q <= s0_ctl_q;
      s2_ctl_q <= '{valid: s1_ctl_q.valid, write: s1_ctl_q.write, behind: (fwd_sum > 0)};
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // Store extrinsic coefficients as the write leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) ext_q[i] <= '0;
    end else if (en_i && s0_ctl_q.valid && s0_ctl_q.write && !s0_idx_q[IDX_W-1]) begin
      ext_q[s0_idx_q[IDX_W-2:0]] <= s0_val_q;
    end
  end

  // Exact forward-row sum for the behind test
  assign fwd_sum = BW'(s1_prod_q[2][0]) + BW'(s1_prod_q[2][1]) + BW'(s1_prod_q[2][2]);

  // Truncate products toward zero and clamp to coordinate width
  always_comb begin
    logic signed [PW-1:0] adj;
    logic signed [PW-1:0] shf;
    adj = '0;
    shf = '0;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 3; k++) begin
        adj = s1_prod_q[r][k] + (s1_prod_q[r][k][PW-1] ? RND : '0);
        shf = adj >>> FRAC_BITS;
        if (shf > SAT_HI) s2_qm_d[r][k] = SAT_HI[COORD_WIDTH-1:0];
        else if (shf < SAT_LO) s2_qm_d[r][k] = SAT_LO[COORD_WIDTH-1:0];
        else s2_qm_d[r][k] = shf[COORD_WIDTH-1:0];
      end
    end
  end

  // Add translation and clamp each camera coordinate
  always_comb begin
    logic signed [SW-1:0] acc;
    acc = '0;
    for (int r = 0; r < 4; r++) begin
      acc = SW'(s2_trans_q[r]) + SW'(s2_qm_q[r][0]) + SW'(s2_qm_q[r][1])
          + SW'(s2_qm_q[r][2]);
      if (acc > SUM_HI) s3_cam_d[r] = SUM_HI[COORD_WIDTH-1:0];
      else if (acc < SUM_LO) s3_cam_d[r] = SUM_LO[COORD_WIDTH-1:0];
      else s3_cam_d[r] = acc[COORD_WIDTH-1:0];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_idx_q <= coef_index_i;
      s0_val_q <= coef_value_i;
      s0_p_q[0] <= point_x_i;
      s0_p_q[1] <= point_y_i;
      s0_p_q[2] <= point_z_i;
      s1_idx_q <= s0_idx_q;
      s1_val_q <= s0_val_q;
      s2_idx_q <= s1_idx_q;
      s2_val_q <= s1_val_q;
      s3_idx_q <= s2_idx_q;
      s3_val_q <= s2_val_q;
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          s1_prod_q[r][k] <= s0_p_q[k] * ext_q[4*k+r];
          s2_qm_q[r][k]   <= s2_qm_d[r][k];
        end
        s1_trans_q[r] <= ext_q[12+r];
        s2_trans_q[r] <= s1_trans_q[r];
        s3_cam_q[r]   <= s3_cam_d[r];
      end
    end
  end

  assign ctl_o      = s3_ctl_q;
  assign wr_index_o = s3_idx_q;
  assign wr_value_o = s3_val_q;
  assign cam_o      = s3_cam_q;

endmodule

/* rtl/ppp_clip.sv */
// Intrinsic stage group: holds the intrinsic matrix and forms clip x, y and w
// over three register stages. Depends on ppp_pkg.
module ppp_clip #(
  parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ppp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  ppp_pkg::ppp_ctl_t                  ctl_i,
  input  logic [ppp_pkg::IDX_W-1:0]          wr_index_i,
  input  logic signed [ppp_pkg::COEF_W-1:0]  wr_value_i,
  input  logic signed [COORD_WIDTH-1:0]      cam_i [4],
  output ppp_pkg::ppp_ctl_t                  ctl_o,
  output logic signed [COORD_WIDTH-1:0]      clip_o [3]
);
  import ppp_pkg::*;

  localparam int PW = COORD_WIDTH + COEF_W;
  localparam int SW = COORD_WIDTH + 2;
  localparam int ROW [3] = '{0, 1, 3};
  localparam logic signed [PW-1:0] RND    = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic signed [PW-1:0] SAT_HI = (PW'(1) << (COORD_WIDTH - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SAT_LO = -(PW'(1) << (COORD_WIDTH - 1));
  localparam logic signed [SW-1:0] SUM_HI = (SW'(1) << (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SUM_LO = -(SW'(1) << (COORD_WIDTH - 1));

  ppp_ctl_t                      c1_ctl_q, c2_ctl_q, c3_ctl_q;
  logic signed [COEF_W-1:0]      intr_q [16];
  logic signed [PW-1:0]          c1_prod_q [3][4];
  logic signed [COORD_WIDTH-1:0] c2_qm_d [3][4];
  logic signed [COORD_WIDTH-1:0] c2_qm_q [3][4];
  logic signed [COORD_WIDTH-1:0] c3_clip_d [3];
  logic signed [COORD_WIDTH-1:0] c3_clip_q [3];

  // Advance control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_ctl_q <= '0;
      c2_ctl_q <= '0;
      c3_ctl_q <= '0;
    end else if (en_i) begin
      c1_ctl_q <= ctl_i;
      c2_ctl_q <= c1_ctl_q;
      c3_ctl_q <= c2_ctl_q;
    end
  end

  // Store intrinsic coefficients as the write leaves this group's input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) intr_q[i] <= '0;
    end else if (en_i && ctl_i.valid && ctl_i.write && wr_index_i[IDX_W-1]) begin
      intr_q[wr_index_i[IDX_W-2:0]] <= wr_value_i;
    end
  end

  // Truncate products toward zero and clamp to coordinate width
  always_comb begin
    logic signed [PW-1:0] adj;
    logic signed [PW-1:0] shf;
    adj = '0;
    shf = '0;
    for (int l = 0; l < 3; l++) begin
      for (int k = 0; k < 4; k++) begin
        adj = c1_prod_q[l][k] + (c1_prod_q[l][k][PW-1] ? RND : '0);
        shf = adj >>> FRAC_BITS;
        if (shf > SAT_HI) c2_qm_d[l][k] = SAT_HI[COORD_WIDTH-1:0];
        else if (shf < SAT_LO) c2_qm_d[l][k] = SAT_LO[COORD_WIDTH-1:0];
        else c2_qm_d[l][k] = shf[COORD_WIDTH-1:0];
      end
    end
  end

  // Sum the four terms and clamp each clip coordinate
  always_comb begin
    logic signed [SW-1:0] acc;
    acc = '0;
    for (int l = 0; l < 3; l++) begin
      acc = SW'(c2_qm_q[l][0]) + SW'(c2_qm_q[l][1]) + SW'(c2_qm_q[l][2])
          + SW'(c2_qm_q[l][3]);
      if (acc > SUM_HI) c3_clip_d[l] = SUM_HI[COORD_WIDTH-1:0];
      else if (acc < SUM_LO) c3_clip_d[l] = SUM_LO[COORD_WIDTH-1:0];
      else c3_clip_d[l] = acc[COORD_WIDTH-1:0];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        for (int k = 0; k < 4; k++) begin
          c1_prod_q[l][k] <= cam_i[k] * intr_q[4*k+ROW[l]];
          c2_qm_q[l][k]   <= c2_qm_d[l][k];
        end
        c3_clip_q[l] <= c3_clip_d[l];
      end
    end
  end

  assign ctl_o  = c3_ctl_q;
  assign clip_o = c3_clip_q;

endmodule

/* rtl/ppp_div.sv */
// Pipelined restoring divider for the x and y lanes with a shared divisor,
// one quotient bit per stage plus an overflow stage. Depends on ppp_pkg.
module ppp_div #(
  parameter int NW = 47,
  parameter int DW = 33
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  ppp_pkg::ppp_tag_t            tag_i,
  input  logic [NW-1:0]                num_x_i,
  input  logic [NW-1:0]                num_y_i,
  input  logic [DW-1:0]                den_i,
  output logic                         valid_o,
  output ppp_pkg::ppp_tag_t            tag_o,
  output logic [ppp_pkg::QUO_W-1:0]    quo_x_o,
  output logic [ppp_pkg::QUO_W-1:0]    quo_y_o,
  output logic                         ovf_x_o,
  output logic                         ovf_y_o
);
  import ppp_pkg::*;

  localparam int RW = ((NW > DW + QUO_W) ? NW : DW + QUO_W) + 1;

  logic             valid_q [QUO_W+1];
  ppp_tag_t         tag_q   [QUO_W+1];
  logic [QUO_W-1:0] qx_q    [QUO_W+1];
  logic [QUO_W-1:0] qy_q    [QUO_W+1];
  logic             ovfx_q  [QUO_W+1];
  logic             ovfy_q  [QUO_W+1];
  logic [RW-1:0]    rx_q    [QUO_W];
  logic [RW-1:0]    ry_q    [QUO_W];
  logic [DW-1:0]    d_q     [QUO_W];
  logic [RW-1:0]    d_top;

  assign d_top = RW'(den_i) << QUO_W;

  // Load the dividend and flag quotients that do not fit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0]  <= tag_i;
      rx_q[0]   <= RW'(num_x_i);
      ry_q[0]   <= RW'(num_y_i);
      d_q[0]    <= den_i;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      ovfx_q[0] <= (RW'(num_x_i) >= d_top);
      ovfy_q[0] <= (RW'(num_y_i) >= d_top);
    end
  end

  // Resolve one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
    localparam int Bit = QUO_W - j;
    logic [RW-1:0] dsh;
    logic          fit_x, fit_y;

    assign dsh   = RW'(d_q[j-1]) << Bit;
    assign fit_x = (rx_q[j-1] >= dsh);
    assign fit_y = (ry_q[j-1] >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= valid_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[j]  <= tag_q[j-1];
        ovfx_q[j] <= ovfx_q[j-1];
        ovfy_q[j] <= ovfy_q[j-1];
        qx_q[j]   <= qx_q[j-1] | (fit_x ? (QUO_W'(1) << Bit) : '0);
        qy_q[j]   <= qy_q[j-1] | (fit_y ? (QUO_W'(1) << Bit) : '0);
      end
    end

    if (j < QUO_W) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rx_q[j] <= fit_x ? rx_q[j-1] - dsh : rx_q[j-1];
          ry_q[j] <= fit_y ? ry_q[j-1] - dsh : ry_q[j-1];
          d_q[j]  <= d_q[j-1];
        end
      end
    end
  end

  assign valid_o = valid_q[QUO_W];
  assign tag_o   = tag_q[QUO_W];
  assign quo_x_o = qx_q[QUO_W];
  assign quo_y_o = qy_q[QUO_W];
  assign ovf_x_o = ovfx_q[QUO_W];
  assign ovf_y_o = ovfy_q[QUO_W];

endmodule

/* rtl/pinhole_point_projection.sv */
// Pinhole point projection: camera and clip transforms, viewport scaling,
// rounding divider and output register. Depends on ppp_pkg, ppp_camera,
// ppp_clip and ppp_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer.
//   action_i low stores coef_value_i in coefficient entry coef_index_i
//   (0-15 extrinsic, 16-31 intrinsic, column-major) and gives no result;
//   action_i high projects point_x/y/z_i and gives one result.
//   Output channel (out_valid_o / out_stall_i) carries pixel_x/y_o,
//   behind_camera_o and status_o. Writes and projections keep their order:
//   a coefficient write affects only points accepted after it.
//   Configuration port (cfg_valid_i / cfg_ready_o) writes viewport width
//   (index 0) or height (index 1); ready is always high. Write it only
//   while no projection is in flight.
//   Path: a result passes the seven transform stages, three scaling stages,
//   the 17-stage divider and the output register. Throughput: one item per
//   cycle while no finished result is stalled at the output.
//   Reset clears the coefficient table to zero, the viewport to 640x480
//   and empties the pipeline. While the receiver stalls a waiting result,
//   the whole pipeline holds and in_stall_o is raised; nothing is lost.
module pinhole_point_projection #(
  parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ppp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ppp_pkg::VP_W-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [ppp_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [ppp_pkg::COEF_W-1:0]   coef_value_i,
  input  logic signed [ppp_pkg::POINT_W-1:0]  point_x_i,
  input  logic signed [ppp_pkg::POINT_W-1:0]  point_y_i,
  input  logic signed [ppp_pkg::POINT_W-1:0]  point_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ppp_pkg::PIX_W-1:0]    pixel_x_o,
  output logic signed [ppp_pkg::PIX_W-1:0]    pixel_y_o,
  output logic                                behind_camera_o,
  output logic [1:0]                          status_o
);
  import ppp_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int NW = COORD_WIDTH + 15;

  typedef struct packed {
    logic                    clamp;
    logic signed [PIX_W-1:0] pix;
  } pix_res_t;

  logic                          en;
  logic [VP_W-1:0]               vp_w_q, vp_h_q;
  ppp_ctl_t                      cam_ctl, clip_ctl;
  logic [IDX_W-1:0]              wr_index;
  logic signed [COEF_W-1:0]      wr_value;
  logic signed [COORD_WIDTH-1:0] cam [4];
  logic signed [COORD_WIDTH-1:0] clip [3];

  logic                          p1_valid_q, p2_valid_q, p3_valid_q;
  logic                          p1_behind_q, p2_behind_q;
  logic signed [DW-1:0]          p1_dx_q, p1_dy_q;
  logic signed [COORD_WIDTH-1:0] p1_w_q, p2_w_q;
  logic signed [NW-1:0]          p2_nx_q, p2_ny_q;
  ppp_tag_t                      p3_tag_q;
  logic [NW-1:0]                 p3_nx_q, p3_ny_q;
  logic [DW-1:0]                 p3_d_q;
  logic [COORD_WIDTH-1:0]        abs_w;
  logic [NW-1:0]                 abs_nx, abs_ny;

  logic                          div_valid;
  ppp_tag_t                      div_tag;
  logic [QUO_W-1:0]              quo_x, quo_y;
  logic                          ovf_x, ovf_y;
  pix_res_t                      res_x, res_y;
  logic signed [PIX_W-1:0]       pix_x_d, pix_y_d;
  status_e                       status_d;

  logic                          out_valid_q;
  logic signed [PIX_W-1:0]       pix_x_q, pix_y_q;
  logic                          behind_q;
  status_e                       status_q;

  // Round and clamp one quotient to a signed pixel
  function automatic pix_res_t round_pix(logic [QUO_W-1:0] q, logic ovf, logic neg);
    pix_res_t res;
    res.clamp = 1'b0;
    if (neg) begin
      if (ovf || (q > (QUO_W'(1) << (PIX_W - 1)))) begin
        res.clamp = 1'b1;
        res.pix   = PIX_MIN;
      end else begin
        res.pix = -$signed(PIX_W'(q));
      end
    end else begin
      if (ovf || (q > QUO_W'(PIX_MAX))) begin
        res.clamp = 1'b1;
        res.pix   = PIX_MAX;
      end else begin
        res.pix = $signed(PIX_W'(q));
      end
    end
    return res;
  endfunction

  // Advance everything unless a finished result is stalled
  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_w_q <= VP_WIDTH_RST;
      vp_h_q <= VP_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VP_WIDTH:  vp_w_q <= cfg_data_i;
        REG_VP_HEIGHT: vp_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ppp_camera #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_camera (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .action_i     (action_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .ctl_o        (cam_ctl),
    .wr_index_o   (wr_index),
    .wr_value_o   (wr_value),
    .cam_o        (cam)
  );

  ppp_clip #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_clip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (cam_ctl),
    .wr_index_i (wr_index),
    .wr_value_i (wr_value),
    .cam_i      (cam),
    .ctl_o      (clip_ctl),
    .clip_o     (clip)
  );

  // Viewport scaling valid bits; write items drop out here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= clip_ctl.valid && !clip_ctl.write;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
    end
  end

  // Magnitudes in the second scaling stage
  assign abs_w  = p2_w_q[COORD_WIDTH-1] ? COORD_WIDTH'(-p2_w_q) : COORD_WIDTH'(p2_w_q);
  assign abs_nx = p2_nx_q[NW-1] ? NW'(-p2_nx_q) : NW'(p2_nx_q);
  assign abs_ny = p2_ny_q[NW-1] ? NW'(-p2_ny_q) : NW'(p2_ny_q);

  // Form w +/- x, scale by viewport, then build dividend and divisor
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_behind_q <= clip_ctl.behind;
      p1_w_q      <= clip[2];
      p1_dx_q     <= clip_ctl.behind ? DW'(clip[2]) - DW'(clip[0])
                                     : DW'(clip[2]) + DW'(clip[0]);
      p1_dy_q     <= clip_ctl.behind ? DW'(clip[2]) - DW'(clip[1])
                                     : DW'(clip[2]) + DW'(clip[1]);
      p2_behind_q <= p1_behind_q;
      p2_w_q      <= p1_w_q;
      p2_nx_q     <= $signed({1'b0, vp_w_q}) * p1_dx_q;
      p2_ny_q     <= $signed({1'b0, vp_h_q}) * p1_dy_q;
      p3_tag_q    <= '{behind: p2_behind_q,
                       w_zero: (p2_w_q == '0),
                       neg_x:  p2_nx_q[NW-1] ^ p2_w_q[COORD_WIDTH-1],
                       neg_y:  p2_ny_q[NW-1] ^ p2_w_q[COORD_WIDTH-1]};
      p3_nx_q     <= abs_nx + NW'(abs_w);
      p3_ny_q     <= abs_ny + NW'(abs_w);
      p3_d_q      <= {abs_w, 1'b0};
    end
  end

  ppp_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p3_valid_q),
    .tag_i   (p3_tag_q),
    .num_x_i (p3_nx_q),
    .num_y_i (p3_ny_q),
    .den_i   (p3_d_q),
    .valid_o (div_valid),
    .tag_o   (div_tag),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .ovf_x_o (ovf_x),
    .ovf_y_o (ovf_y)
  );

  // Round, clamp and classify the result
  assign res_x = round_pix(quo_x, ovf_x, div_tag.neg_x);
  assign res_y = round_pix(quo_y, ovf_y, div_tag.neg_y);

  always_comb begin
    if (div_tag.w_zero) begin
      pix_x_d  = '0;
      pix_y_d  = '0;
      status_d = STATUS_W_ZERO;
    end else begin
      pix_x_d  = res_x.pix;
      pix_y_d  = res_y.pix;
      status_d = (res_x.clamp || res_y.clamp) ? STATUS_SAT : STATUS_OK;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_x_q  <= pix_x_d;
      pix_y_q  <= pix_y_d;
      behind_q <= div_tag.behind;
      status_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = pix_x_q;
  assign pixel_y_o       = pix_y_q;
  assign behind_camera_o = behind_q;
  assign status_o        = status_q;

endmodule

/* rtl/ppp_checker.sv */
// Port-level checker for the pinhole point projection, bound to the top level.
// Depends on ppp_pkg and the top-level port names.
module ppp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [ppp_pkg::PIX_W-1:0] pixel_x_o,
  input logic signed [ppp_pkg::PIX_W-1:0] pixel_y_o,
  input logic [1:0]                       status_o
);
  import ppp_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o)
      && $stable(status_o))
    else $error("stalled result changed");

  // Stall the input only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Give zero pixels when w is zero
  a_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_W_ZERO) |-> (pixel_x_o == 0) && (pixel_y_o == 0))
    else $error("w-zero result with nonzero pixel");

  // Show a clamped pixel when saturation is flagged
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_SAT) |->
      (pixel_x_o == PIX_MAX) || (pixel_x_o == PIX_MIN) ||
      (pixel_y_o == PIX_MAX) || (pixel_y_o == PIX_MIN))
    else $error("saturation flagged without clamped pixel");

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (.*);
